### design/ttei_pkg.sv
`default_nettype none

package ttei_pkg;

   localparam int LEVEL_BITS          = 16;
   localparam int INDEX_BITS          = 6;
   localparam int TICKS_BITS          = 8;
   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam logic [TICKS_BITS-1:0] TICKS_RESET = 8'd10;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_TRIGGER = 2'd1,
      OP_WRITE   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [INDEX_BITS-1:0]   entry_index;
      logic [LEVEL_BITS-1:0]   entry_level;
      logic                    entry_null;
   } req_payload_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0]   level;
      logic                    level_null;
      logic                    active;
   } rsp_payload_type;

   typedef struct packed {
      logic                    is_null;
      logic [LEVEL_BITS-1:0]   lvl;
   } entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_READ_A,
      ST_READ_B,
      ST_STEP,
      ST_DIVIDE,
      ST_READ_OUT,
      ST_MULTIPLY,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

### design/ttei_ram.sv
`default_nettype none

module ttei_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### design/ttei_div.sv
`default_nettype none

module ttei_div #(
   parameter int W = 16,
   parameter int D = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [D-1:0] divisor,
   output logic              done,
   output logic      [W-1:0] quotient
);

   localparam int CW = $clog2(W);

   logic [D-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [D-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [D:0]    trial;
   logic          fits;

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, quo_ff[W-1]};
      fits     = trial >= {1'b0, dvs_ff};
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? D'(trial - {1'b0, dvs_ff}) : D'(trial);
         quo_in   = {quo_ff[W-2:0], fits};
         count_in = count_ff + CW'(1);
         if (count_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### design/triggered_table_envelope_interpolator_top.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_data  (op, entry_index, entry_level, entry_null)
// rsp       out        rsp_valid/rsp_ready    rsp_data  (level, level_null, active)
// csr       in         APB, pready always 1   ticks_per_entry at every csr_paddr
//
// One transfer is taken at a time. A write, a plain tick or a no-op passes through DECODE,
// READ_OUT, MULTIPLY and RESULT; once the output register is free its result is valid as req_ready returns high.
// A trigger or an entry boundary adds 2 table reads (READ_A, READ_B) and a STEP state,
// plus a serial divide unless the entry is the last one or either entry is null.
// After reset every table entry is swept to zero while req_ready is low.
// A result waits in an output register until rsp_ready takes it.

module triggered_table_envelope_interpolator_top
#(
   parameter int TABLE_DEPTH = ttei_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire ttei_pkg::req_payload_type req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output ttei_pkg::rsp_payload_type      rsp_data,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [1:0]                csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic      [31:0]               csr_prdata,
   output logic                           csr_pready
);

   import ttei_pkg::*;

   localparam int PW     = $clog2(TABLE_DEPTH);
   localparam int EW     = LEVEL_BITS + 1;
   localparam int PROD_W = LEVEL_BITS + 10;
   localparam int SUM_W  = LEVEL_BITS + 11;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

   state_type                      state_ff, state_in;
   logic [PW-1:0]                  clr_ff, clr_in;
   req_payload_type                item_ff, item_in;
   logic [PW-1:0]                  pos_ff, pos_in;
   logic                           playing_ff, playing_in;
   logic [TICKS_BITS-1:0]          tick_ff, tick_in;
   logic signed [EW-1:0]           step_ff, step_in;
   logic [TICKS_BITS-1:0]          ticks_ff, ticks_in;
   entry_type                      ent0_ff, ent0_in;
   logic                           neg_ff, neg_in;
   entry_type                      entry_ff, entry_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_payload_type                rsp_data_ff, rsp_data_in;

   logic                           ram_we;
   logic [PW-1:0]                  ram_waddr;
   entry_type                      ram_wdata;
   logic [PW-1:0]                  ram_raddr;
   entry_type                      ram_rdata;

   logic                           div_start;
   logic                           div_done;
   logic [LEVEL_BITS-1:0]          div_quotient;
   logic [LEVEL_BITS-1:0]          div_dividend;

   logic                           last_pos;
   logic [TICKS_BITS-1:0]          eff_ticks;
   logic [TICKS_BITS-1:0]          tick_next;
   logic signed [EW-1:0]           diff;
   logic signed [EW-1:0]           diff_abs;
   logic signed [EW-1:0]           quo_signed;
   logic signed [SUM_W-1:0]        sum;
   logic [LEVEL_BITS-1:0]          sat_level;

   ttei_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ttei_div #(
      .W (LEVEL_BITS),
      .D (TICKS_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (eff_ticks),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign last_pos     = pos_ff == PW'(TABLE_DEPTH - 1);
   assign eff_ticks    = (ticks_ff == '0) ? TICKS_BITS'(1) : ticks_ff;
   assign tick_next    = tick_ff + TICKS_BITS'(1);
   assign diff         = $signed({1'b0, ram_rdata.lvl}) - $signed({1'b0, ent0_ff.lvl});
   assign diff_abs     = (diff < 0) ? -diff : diff;
   assign div_dividend = diff_abs[LEVEL_BITS-1:0];
   assign quo_signed   = neg_ff ? -$signed({1'b0, div_quotient}) : $signed({1'b0, div_quotient});
   assign sum          = SUM_W'($signed({1'b0, entry_ff.lvl})) + SUM_W'(prod_ff);

   always_comb begin
      if (sum < 0) begin
         sat_level = '0;
      end else if (sum > SUM_W'({1'b0, LEVEL_MAX})) begin
         sat_level = LEVEL_MAX;
      end else begin
         sat_level = sum[LEVEL_BITS-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      item_in      = item_ff;
      pos_in       = pos_ff;
      playing_in   = playing_ff;
      tick_in      = tick_ff;
      step_in      = step_ff;
      ticks_in     = ticks_ff;
      ent0_in      = ent0_ff;
      neg_in       = neg_ff;
      entry_in     = entry_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = '0;
      ram_raddr    = pos_ff;
      div_start    = 1'b0;

      if (csr_psel && csr_penable && csr_pwrite) begin
         ticks_in = csr_pwdata[TICKS_BITS-1:0];
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + PW'(1);
            if (clr_ff == PW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_READ_OUT;
            case (item_ff.op)
               OP_TICK: begin
                  if (playing_ff) begin
                     if (tick_next >= eff_ticks) begin
                        tick_in = '0;
                        step_in = '0;
                        if (last_pos) begin
                           playing_in = 1'b0;
                           pos_in     = '0;
                        end else begin
                           pos_in   = pos_ff + PW'(1);
                           state_in = ST_READ_A;
                        end
                     end else begin
                        tick_in = tick_next;
                     end
                  end
               end
               OP_TRIGGER: begin
                  playing_in = 1'b1;
                  pos_in     = '0;
                  tick_in    = '0;
                  state_in   = ST_READ_A;
               end
               OP_WRITE: begin
                  ram_we    = 32'(item_ff.entry_index) < 32'(TABLE_DEPTH);
                  ram_waddr = PW'(item_ff.entry_index);
                  ram_wdata = {item_ff.entry_null, item_ff.entry_level};
               end
               OP_NONE: begin
                  state_in = ST_READ_OUT;
               end
               default: begin
                  state_in = ST_READ_OUT;
               end
            endcase
         end
         ST_READ_A: begin
            ram_raddr = pos_ff;
            state_in  = ST_READ_B;
         end
         ST_READ_B: begin
            ram_raddr = last_pos ? pos_ff : pos_ff + PW'(1);
            ent0_in   = ram_rdata;
            state_in  = ST_STEP;
         end
         ST_STEP: begin
            if (last_pos || ent0_ff.is_null || ram_rdata.is_null) begin
               step_in  = '0;
               state_in = ST_READ_OUT;
            end else begin
               div_start = 1'b1;
               neg_in    = diff < 0;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               step_in  = quo_signed;
               state_in = ST_READ_OUT;
            end
         end
         ST_READ_OUT: begin
            ram_raddr = pos_ff;
            state_in  = ST_MULTIPLY;
         end
         ST_MULTIPLY: begin
            entry_in = ram_rdata;
            prod_in  = PROD_W'($signed({1'b0, tick_ff})) * PROD_W'(step_ff);
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.active = playing_ff;
               if (playing_ff && !entry_ff.is_null) begin
                  rsp_data_in.level      = sat_level;
                  rsp_data_in.level_null = 1'b0;
               end else begin
                  rsp_data_in.level      = '0;
                  rsp_data_in.level_null = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pos_ff       <= '0;
         playing_ff   <= 1'b0;
         tick_ff      <= '0;
         step_ff      <= '0;
         ticks_ff     <= TICKS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pos_ff       <= pos_in;
         playing_ff   <= playing_in;
         tick_ff      <= tick_in;
         step_ff      <= step_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      ent0_ff     <= ent0_in;
      neg_ff      <= neg_in;
      entry_ff    <= entry_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready  = state_ff == ST_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_prdata = 32'(ticks_ff) | 32'(csr_paddr & 2'b00);
   assign csr_pready = 1'b1;

endmodule

`default_nettype wire
